// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ACSR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ACSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  `ACSR_ASSERT(lbl, clk, rstn, (ante) |=> (cons), msg)

`endif

// ===== rtl/acsr_pkg.sv =====
package acsr_pkg;

  localparam int SLOTS    = 8;
  localparam int AGE_BITS = 16;

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FILL_W = $clog2(SLOTS + 1);

  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_TOUCH = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  slot;
    logic [63:0] record_word;
    logic [31:0] event_ref;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  slot_index;
    logic        evicted;
    logic        hit_valid;
    logic [63:0] record_out;
    logic [31:0] event_out;
  } out_item_t;

  // Per-cell command for the current cycle.
  typedef struct packed {
    logic tick;
    logic clear;
    logic write;
  } cell_cmd_t;

  // Oldest-slot search token passed down the cell row.
  typedef struct packed {
    logic                vld;
    logic [IDX_W-1:0]    idx;
    logic [AGE_BITS-1:0] age;
  } scan_t;

endpackage

// ===== rtl/acsr_cell.sv =====
module acsr_cell import acsr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  cell_cmd_t        cmd,
  input  logic [63:0]      wr_record,
  input  logic [31:0]      wr_event,
  input  scan_t            scan_in,
  output scan_t            scan_out,
  output logic [63:0]      rec_q,
  output logic [31:0]      evt_q
);

  logic [AGE_BITS-1:0] age_r, age_nxt;
  logic [63:0]         rec_r;
  logic [31:0]         evt_r;
  scan_t               scan_r, scan_nxt;

  // Saturating age: clear on write or touch, advance on tick.
  always_comb begin
    age_nxt = age_r;
    if (cmd.clear || cmd.write) begin
      age_nxt = '0;
    end else if (cmd.tick && (age_r != AGE_MAX)) begin
      age_nxt = age_r + 1'b1;
    end
  end

  // Take over the token only on a strictly greater age, so ties keep the lower index.
  always_comb begin
    scan_nxt = scan_in;
    if (scan_in.vld && (age_r > scan_in.age)) begin
      scan_nxt.idx = cell_idx;
      scan_nxt.age = age_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_r  <= '0;
      scan_r <= '0;
    end else begin
      age_r  <= age_nxt;
      scan_r <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      rec_r <= wr_record;
      evt_r <= wr_event;
    end
  end

  assign scan_out = scan_r;
  assign rec_q    = rec_r;
  assign evt_q    = evt_r;

endmodule

// ===== rtl/aging_cache_slot_replacement.sv =====
// Results: tick gives no result; touch and allocate into a free slot show their result
//   in the cycle after the transfer; allocate into a full cache shows it after the victim write.
// Throughput: one item per cycle for ticks, touches and allocates while free slots remain
//   and the output is not stalled; an allocate into a full cache stalls the input until the
//   search token has walked the cell row one cell per cycle and the victim has been written.
// Reset: synchronous, active low; clears fill count, all ages, search and output valid.
module aging_cache_slot_replacement import acsr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int CMP_W = (FILL_W > 3) ? FILL_W : 3;

  localparam logic [1:0] ST_IDLE = 2'd0;  // take items
  localparam logic [1:0] ST_SCAN = 2'd1;  // search token walks the cells
  localparam logic [1:0] ST_FIN  = 2'd2;  // write victim once the output is free

  logic [1:0]        state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0]  victim_r;
  logic [63:0]       pend_rec_r;
  logic [31:0]       pend_evt_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic             in_xfer, out_free, full;
  logic             is_tick, alloc_fill, alloc_scan, is_touch, touch_hit, fin_go;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx, touch_idx;
  logic [63:0]      wr_rec;
  logic [31:0]      wr_evt;

  cell_cmd_t   cmd  [SLOTS];
  scan_t       scan [SLOTS+1];
  logic [63:0] cell_rec [SLOTS];
  logic [31:0] cell_evt [SLOTS];

  // Hold the input while a search or its victim write is pending, or the output cannot take a new result.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_xfer  = in_valid && !in_stall;

  assign full       = (fill_r == FILL_W'(SLOTS));
  assign is_tick    = in_xfer && (in_data.op == OP_TICK);
  assign alloc_fill = in_xfer && (in_data.op == OP_ALLOC) && !full;
  assign alloc_scan = in_xfer && (in_data.op == OP_ALLOC) && full;
  assign is_touch   = in_xfer && (in_data.op == OP_TOUCH);
  // A touch counts only for a slot below the fill count.
  assign touch_hit  = is_touch && (CMP_W'(in_data.slot) < CMP_W'(fill_r));
  assign touch_idx  = IDX_W'(in_data.slot);
  assign fin_go     = (state_r == ST_FIN) && out_free;

  // One write port: the next free slot, or the victim found by the search.
  assign wr_en  = alloc_fill || fin_go;
  assign wr_idx = (state_r == ST_FIN) ? victim_r : fill_r[IDX_W-1:0];
  assign wr_rec = (state_r == ST_FIN) ? pend_rec_r : in_data.record_word;
  assign wr_evt = (state_r == ST_FIN) ? pend_evt_r : in_data.event_ref;

  // Launch the search token at cell 0 with age zero, so all-zero ages pick slot 0.
  assign scan[0].vld = alloc_scan;
  assign scan[0].idx = '0;
  assign scan[0].age = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    assign cmd[i].tick  = is_tick;
    assign cmd[i].clear = touch_hit && (touch_idx == IDX_W'(i));
    assign cmd[i].write = wr_en && (wr_idx == IDX_W'(i));

    acsr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .cmd      (cmd[i]),
      .wr_record(wr_rec),
      .wr_event (wr_evt),
      .scan_in  (scan[i]),
      .scan_out (scan[i+1]),
      .rec_q    (cell_rec[i]),
      .evt_q    (cell_evt[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (alloc_scan) begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: if (scan[SLOTS].vld) begin
        state_nxt = ST_FIN;
      end
      ST_FIN: if (fin_go) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign fill_nxt = alloc_fill ? fill_r + 1'b1 : fill_r;

  // Build the next result; drop the current one once the far side takes it.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (alloc_fill || fin_go) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.slot_index = 3'(wr_idx);
      out_data_nxt.evicted    = fin_go;
      out_data_nxt.hit_valid  = 1'b1;
      out_data_nxt.record_out = '0;
      out_data_nxt.event_out  = '0;
    end else if (is_touch) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.slot_index = in_data.slot;
      out_data_nxt.evicted    = 1'b0;
      out_data_nxt.hit_valid  = touch_hit;
      out_data_nxt.record_out = touch_hit ? cell_rec[touch_idx] : '0;
      out_data_nxt.event_out  = touch_hit ? cell_evt[touch_idx] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (alloc_scan) begin
      pend_rec_r <= in_data.record_word;
      pend_evt_r <= in_data.event_ref;
    end
    if (scan[SLOTS].vld) begin
      victim_r <= scan[SLOTS].idx;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/acsr_checker.sv =====
`include "assert_macros.svh"

module acsr_checker import acsr_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  `ACSR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")

  `ACSR_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data), "stalled result changed")

  `ACSR_ASSERT_NEXT(a_tick_silent, clk, rst_n, in_valid && !in_stall && (in_data.op == OP_TICK) && !(out_valid && out_stall), !out_valid, "tick produced a result")

  `ACSR_ASSERT_NEXT(a_touch_echo, clk, rst_n, in_valid && !in_stall && (in_data.op == OP_TOUCH), out_valid && (out_data.slot_index == $past(in_data.slot)), "touch result missing or wrong slot")

endmodule

bind aging_cache_slot_replacement acsr_checker u_acsr_checker (.*);
